[hdl/calendar_date_arithmetic_defines.svh]
// Assertion macros for the checker file of the calendar date block.
// Each macro expands to one labeled concurrent assertion on clk, idle in reset.
`ifndef CALENDAR_DATE_ARITHMETIC_DEFINES_SVH
`define CALENDAR_DATE_ARITHMETIC_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar date check failed");

// Consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar date check failed");

`endif

[hdl/cda_pkg.sv]
// Package for the calendar date block: field types, command and status codes,
// sequencer types and the month length table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  localparam int MAX_YEAR    = 9999;
  localparam int COUNT_WIDTH = 16;

  localparam int CMD_W    = 3;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int ADD_W    = 16;
  localparam int ORDER_W  = 2;
  localparam int DIFF_W   = 23;
  localparam int STATUS_W = 2;

  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic [DAY_W-1:0]          day_t;
  typedef logic [MONTH_W-1:0]        month_t;
  typedef logic [YEAR_W-1:0]         year_t;
  typedef logic [ADD_W-1:0]          add_t;
  typedef logic signed [ORDER_W-1:0] order_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [STATUS_W-1:0]       status_t;

  localparam cmd_t CMD_VALIDATE     = 3'd0;
  localparam cmd_t CMD_COMPARE      = 3'd1;
  localparam cmd_t CMD_NEXT_DAY     = 3'd2;
  localparam cmd_t CMD_ADD_DAYS     = 3'd3;
  localparam cmd_t CMD_DAYS_BETWEEN = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_INVALID  = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  localparam order_t ORD_EARLIER = -2'sd1;
  localparam order_t ORD_EQUAL   = 2'sd0;
  localparam order_t ORD_LATER   = 2'sd1;

  // Day serial of the last representable date, 31 Dec of MAX_YEAR.
  localparam int LAST_SERIAL = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                               + MAX_YEAR / 400 - 1;
  localparam int SER_NEED    = $clog2(LAST_SERIAL + (2 ** COUNT_WIDTH) + 1);
  // Wide enough for the 400-year day step too.
  localparam int SERIAL_W    = (SER_NEED > 18) ? SER_NEED : 18;
  typedef logic [SERIAL_W-1:0] serial_t;

  localparam add_t COUNT_MASK = (COUNT_WIDTH >= ADD_W) ? '1
                                : add_t'((1 << COUNT_WIDTH) - 1);

  // Step counter inside one decomposition phase (at most 24 steps).
  localparam int CNT_W = 5;
  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t CNT_CAP    = 5'd3;
  localparam cnt_t CNT_FULL_4 = 5'd24;

  localparam month_t JANUARY  = 4'd1;
  localparam month_t FEBRUARY = 4'd2;
  localparam month_t DECEMBER = 4'd12;
  localparam day_t   LEAP_FEB = 5'd29;

  localparam day_t MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATE,
    S_YEAR,
    S_MONTH,
    S_OP,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PASS_A,
    PASS_B,
    PASS_CONV
  } pass_t;

  typedef enum logic [1:0] {
    PH_400,
    PH_100,
    PH_4,
    PH_1
  } phase_t;

  function automatic day_t month_days(month_t m, logic leap);
    if (m < JANUARY || m > DECEMBER) begin
      return '0;
    end
    if (m == FEBRUARY && leap) begin
      return LEAP_FEB;
    end
    return MONTH_LEN[4'(m - JANUARY)];
  endfunction

  function automatic serial_t year_step(phase_t ph);
    case (ph)
      PH_400:  return serial_t'(400);
      PH_100:  return serial_t'(100);
      PH_4:    return serial_t'(4);
      default: return serial_t'(1);
    endcase
  endfunction

  function automatic serial_t day_step(phase_t ph);
    case (ph)
      PH_400:  return serial_t'(146097);
      PH_100:  return serial_t'(36524);
      PH_4:    return serial_t'(1461);
      default: return serial_t'(365);
    endcase
  endfunction

  // Century and single-year phases stop at three steps.
  function automatic logic phase_capped(phase_t ph);
    case (ph)
      PH_100:  return 1'b1;
      PH_1:    return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

[hdl/cda_if.sv]
// Valid/ready channel interfaces for the calendar date block: command items in,
// result items out. Depends on cda_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cda_in_if;
  logic            valid;
  logic            ready;
  cda_pkg::cmd_t   cmd;
  cda_pkg::day_t   day_a;
  cda_pkg::month_t month_a;
  cda_pkg::year_t  year_a;
  cda_pkg::day_t   day_b;
  cda_pkg::month_t month_b;
  cda_pkg::year_t  year_b;
  cda_pkg::add_t   add_count;

  modport source (
    output valid, cmd, day_a, month_a, year_a, day_b, month_b, year_b, add_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, day_a, month_a, year_a, day_b, month_b, year_b, add_count,
    output ready
  );
endinterface

interface cda_out_if;
  logic             valid;
  logic             ready;
  cda_pkg::day_t    res_day;
  cda_pkg::month_t  res_month;
  cda_pkg::year_t   res_year;
  cda_pkg::order_t  order;
  cda_pkg::diff_t   day_difference;
  logic             first_valid;
  logic             second_valid;
  cda_pkg::status_t status;

  modport source (
    output valid, res_day, res_month, res_year, order, day_difference,
           first_valid, second_valid, status,
    input  ready
  );
  modport sink (
    input  valid, res_day, res_month, res_year, order, day_difference,
           first_valid, second_valid, status,
    output ready
  );
endinterface

`default_nettype wire

[hdl/calendar_date_arithmetic.sv]
// Gregorian date engine top level: validate, compare, next day, add days and
// day difference under one sequencer. Depends on cda_pkg and cda_if.
`timescale 1ns / 1ps
`default_nettype none

// One item at a time: in_ch.ready is high only while the sequencer is idle,
// and an accepted item runs through the sequencer until its result item is
// registered, holding first for the output register if that is still full.
// The work is done by a single compare-and-subtract loop that is run once per
// date and once more to turn a day serial back into a date: it peels 400-,
// 100-, 4- and 1-year blocks off the year (or their day counts off the
// serial), one block per cycle, then walks the months one per cycle. Leap
// years fall out of the block counts, so no divider is needed. The result
// sits in an output register, so the next item is taken while a finished
// result still waits on out_ch.ready.
module calendar_date_arithmetic (
  input  logic      clk,
  input  logic      rst_n,
  cda_in_if.sink    in_ch,
  cda_out_if.source out_ch
);

  localparam int DW = (cda_pkg::SERIAL_W + 1 > cda_pkg::DIFF_W) ?
                      cda_pkg::SERIAL_W + 1 : cda_pkg::DIFF_W;

  // Sequencer control.
  cda_pkg::state_t  state_r, state_nxt;
  cda_pkg::pass_t   pass_r, pass_nxt;
  cda_pkg::phase_t  phase_r, phase_nxt;
  cda_pkg::cnt_t    cnt_r, cnt_nxt;
  cda_pkg::month_t  mon_r, mon_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working datapath.
  cda_pkg::serial_t rem_r, rem_nxt;
  cda_pkg::serial_t acc_r, acc_nxt;
  cda_pkg::serial_t sa_r, sa_nxt;
  cda_pkg::serial_t sb_r, sb_nxt;
  logic             leap_r, leap_nxt;
  logic             b3_r, b3_nxt;
  logic             c24_r, c24_nxt;

  // Latched item.
  cda_pkg::cmd_t    cmd_r, cmd_nxt;
  cda_pkg::day_t    da_r, da_nxt, db_r, db_nxt;
  cda_pkg::month_t  ma_r, ma_nxt, mb_r, mb_nxt;
  cda_pkg::year_t   ya_r, ya_nxt, yb_r, yb_nxt;
  cda_pkg::add_t    addc_r, addc_nxt;

  // Result under construction.
  logic             va_r, va_nxt, vb_r, vb_nxt;
  cda_pkg::day_t    rday_r, rday_nxt;
  cda_pkg::month_t  rmon_r, rmon_nxt;
  cda_pkg::year_t   ryear_r, ryear_nxt;
  cda_pkg::order_t  ord_r, ord_nxt;
  cda_pkg::diff_t   diff_r, diff_nxt;
  cda_pkg::status_t st_r, st_nxt;

  // Output register.
  cda_pkg::day_t    o_day_r, o_day_nxt;
  cda_pkg::month_t  o_mon_r, o_mon_nxt;
  cda_pkg::year_t   o_year_r, o_year_nxt;
  cda_pkg::order_t  o_ord_r, o_ord_nxt;
  cda_pkg::diff_t   o_diff_r, o_diff_nxt;
  logic             o_va_r, o_va_nxt, o_vb_r, o_vb_nxt;
  cda_pkg::status_t o_st_r, o_st_nxt;

  // Shared step unit signals.
  cda_pkg::day_t    cur_day;
  cda_pkg::month_t  cur_mon;
  cda_pkg::year_t   cur_year;
  logic             conv;
  cda_pkg::serial_t sub_amt, add_amt;
  logic             at_cap, year_go, leap_now, year_ok, date_ok;
  cda_pkg::day_t    md;
  cda_pkg::serial_t step_sum;
  logic [DW-1:0]    diff_wide;
  logic             in_acc;

  assign in_ch.ready = (state_r == cda_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_day        = o_day_r;
  assign out_ch.res_month      = o_mon_r;
  assign out_ch.res_year       = o_year_r;
  assign out_ch.order          = o_ord_r;
  assign out_ch.day_difference = o_diff_r;
  assign out_ch.first_valid    = o_va_r;
  assign out_ch.second_valid   = o_vb_r;
  assign out_ch.status         = o_st_r;

  // Date under work for the current pass.
  assign cur_day  = (pass_r == cda_pkg::PASS_B) ? db_r : da_r;
  assign cur_mon  = (pass_r == cda_pkg::PASS_B) ? mb_r : ma_r;
  assign cur_year = (pass_r == cda_pkg::PASS_B) ? yb_r : ya_r;
  assign conv     = (pass_r == cda_pkg::PASS_CONV);

  // Years to days while encoding a date, days to years while decoding one.
  assign sub_amt  = conv ? cda_pkg::day_step(phase_r) : cda_pkg::year_step(phase_r);
  assign add_amt  = conv ? cda_pkg::year_step(phase_r) : cda_pkg::day_step(phase_r);
  assign at_cap   = cda_pkg::phase_capped(phase_r) && (cnt_r == cda_pkg::CNT_CAP);
  assign year_go  = (rem_r >= sub_amt) && !at_cap;

  // With year-1 = 400a + 100b + 4c + e: divisible by 4 when e is 3, by 100
  // when c is also 24, by 400 when b is also 3.
  assign leap_now = (cnt_r == cda_pkg::CNT_CAP) && (!c24_r || b3_r);

  assign year_ok  = (cur_year != '0) && (int'(cur_year) <= cda_pkg::MAX_YEAR);
  assign date_ok  = (cur_mon >= cda_pkg::JANUARY) && (cur_mon <= cda_pkg::DECEMBER)
                    && (cur_day != '0)
                    && (cur_day <= cda_pkg::month_days(cur_mon, leap_now));

  assign md        = cda_pkg::month_days(mon_r, leap_r);
  assign step_sum  = sa_r + ((cmd_r == cda_pkg::CMD_NEXT_DAY) ?
                             cda_pkg::serial_t'(1) : cda_pkg::serial_t'(addc_r));
  assign diff_wide = DW'(sb_r) - DW'(sa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cda_pkg::S_IDLE;
      pass_r      <= cda_pkg::PASS_A;
      phase_r     <= cda_pkg::PH_400;
      cnt_r       <= '0;
      mon_r       <= cda_pkg::JANUARY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      mon_r       <= mon_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    sa_r     <= sa_nxt;
    sb_r     <= sb_nxt;
    leap_r   <= leap_nxt;
    b3_r     <= b3_nxt;
    c24_r    <= c24_nxt;
    cmd_r    <= cmd_nxt;
    da_r     <= da_nxt;
    ma_r     <= ma_nxt;
    ya_r     <= ya_nxt;
    db_r     <= db_nxt;
    mb_r     <= mb_nxt;
    yb_r     <= yb_nxt;
    addc_r   <= addc_nxt;
    va_r     <= va_nxt;
    vb_r     <= vb_nxt;
    rday_r   <= rday_nxt;
    rmon_r   <= rmon_nxt;
    ryear_r  <= ryear_nxt;
    ord_r    <= ord_nxt;
    diff_r   <= diff_nxt;
    st_r     <= st_nxt;
    o_day_r  <= o_day_nxt;
    o_mon_r  <= o_mon_nxt;
    o_year_r <= o_year_nxt;
    o_ord_r  <= o_ord_nxt;
    o_diff_r <= o_diff_nxt;
    o_va_r   <= o_va_nxt;
    o_vb_r   <= o_vb_nxt;
    o_st_r   <= o_st_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    mon_nxt    = mon_r;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    sa_nxt     = sa_r;
    sb_nxt     = sb_r;
    leap_nxt   = leap_r;
    b3_nxt     = b3_r;
    c24_nxt    = c24_r;
    cmd_nxt    = cmd_r;
    da_nxt     = da_r;
    ma_nxt     = ma_r;
    ya_nxt     = ya_r;
    db_nxt     = db_r;
    mb_nxt     = mb_r;
    yb_nxt     = yb_r;
    addc_nxt   = addc_r;
    va_nxt     = va_r;
    vb_nxt     = vb_r;
    rday_nxt   = rday_r;
    rmon_nxt   = rmon_r;
    ryear_nxt  = ryear_r;
    ord_nxt    = ord_r;
    diff_nxt   = diff_r;
    st_nxt     = st_r;
    o_day_nxt  = o_day_r;
    o_mon_nxt  = o_mon_r;
    o_year_nxt = o_year_r;
    o_ord_nxt  = o_ord_r;
    o_diff_nxt = o_diff_r;
    o_va_nxt   = o_va_r;
    o_vb_nxt   = o_vb_r;
    o_st_nxt   = o_st_r;

    // Drop the shown result once it is taken.
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      cda_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_ch.cmd;
          da_nxt    = in_ch.day_a;
          ma_nxt    = in_ch.month_a;
          ya_nxt    = in_ch.year_a;
          db_nxt    = in_ch.day_b;
          mb_nxt    = in_ch.month_b;
          yb_nxt    = in_ch.year_b;
          addc_nxt  = in_ch.add_count & cda_pkg::COUNT_MASK;
          va_nxt    = 1'b0;
          vb_nxt    = 1'b0;
          rday_nxt  = '0;
          rmon_nxt  = '0;
          ryear_nxt = '0;
          ord_nxt   = cda_pkg::ORD_EQUAL;
          diff_nxt  = '0;
          st_nxt    = cda_pkg::ST_OK;
          pass_nxt  = cda_pkg::PASS_A;
          state_nxt = cda_pkg::S_DATE;
        end
      end

      cda_pkg::S_DATE: begin
        // Start encoding this pass's date, or skip it when the year is out.
        if (year_ok) begin
          rem_nxt   = cda_pkg::serial_t'(cur_year - 1'b1);
          acc_nxt   = '0;
          phase_nxt = cda_pkg::PH_400;
          cnt_nxt   = '0;
          state_nxt = cda_pkg::S_YEAR;
        end else if (pass_r == cda_pkg::PASS_A) begin
          pass_nxt  = cda_pkg::PASS_B;
        end else begin
          state_nxt = cda_pkg::S_OP;
        end
      end

      cda_pkg::S_YEAR: begin
        if (year_go) begin
          rem_nxt = rem_r - sub_amt;
          acc_nxt = acc_r + add_amt;
          if (phase_r != cda_pkg::PH_400) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          cnt_nxt = '0;
          case (phase_r)
            cda_pkg::PH_400: phase_nxt = cda_pkg::PH_100;
            cda_pkg::PH_100: begin
              b3_nxt    = (cnt_r == cda_pkg::CNT_CAP);
              phase_nxt = cda_pkg::PH_4;
            end
            cda_pkg::PH_4: begin
              c24_nxt   = (cnt_r == cda_pkg::CNT_FULL_4);
              phase_nxt = cda_pkg::PH_1;
            end
            default: begin
              leap_nxt = leap_now;
              mon_nxt  = cda_pkg::JANUARY;
              if (conv) begin
                state_nxt = cda_pkg::S_MONTH;
              end else begin
                if (pass_r == cda_pkg::PASS_A) begin
                  va_nxt = date_ok;
                end else begin
                  vb_nxt = date_ok;
                end
                if (date_ok) begin
                  state_nxt = cda_pkg::S_MONTH;
                end else if (pass_r == cda_pkg::PASS_A) begin
                  pass_nxt  = cda_pkg::PASS_B;
                  state_nxt = cda_pkg::S_DATE;
                end else begin
                  state_nxt = cda_pkg::S_OP;
                end
              end
            end
          endcase
        end
      end

      cda_pkg::S_MONTH: begin
        if (conv) begin
          // Peel whole months off the remaining days.
          if (mon_r < cda_pkg::DECEMBER && rem_r >= cda_pkg::serial_t'(md)) begin
            rem_nxt = rem_r - cda_pkg::serial_t'(md);
            mon_nxt = mon_r + 1'b1;
          end else begin
            rday_nxt  = cda_pkg::day_t'(rem_r + 1'b1);
            rmon_nxt  = mon_r;
            ryear_nxt = cda_pkg::year_t'(acc_r + 1'b1);
            state_nxt = cda_pkg::S_DONE;
          end
        end else if (mon_r < cur_mon) begin
          acc_nxt = acc_r + cda_pkg::serial_t'(md);
          mon_nxt = mon_r + 1'b1;
        end else begin
          if (pass_r == cda_pkg::PASS_A) begin
            sa_nxt    = acc_r + cda_pkg::serial_t'(cur_day) - 1'b1;
            pass_nxt  = cda_pkg::PASS_B;
            state_nxt = cda_pkg::S_DATE;
          end else begin
            sb_nxt    = acc_r + cda_pkg::serial_t'(cur_day) - 1'b1;
            state_nxt = cda_pkg::S_OP;
          end
        end
      end

      cda_pkg::S_OP: begin
        state_nxt = cda_pkg::S_DONE;
        case (cmd_r)
          cda_pkg::CMD_COMPARE: begin
            if (!va_r || !vb_r) begin
              st_nxt = cda_pkg::ST_INVALID;
            end else if (sa_r < sb_r) begin
              ord_nxt = cda_pkg::ORD_EARLIER;
            end else if (sa_r > sb_r) begin
              ord_nxt = cda_pkg::ORD_LATER;
            end
          end
          cda_pkg::CMD_DAYS_BETWEEN: begin
            if (!va_r || !vb_r) begin
              st_nxt = cda_pkg::ST_INVALID;
            end else begin
              diff_nxt = diff_wide[cda_pkg::DIFF_W-1:0];
            end
          end
          cda_pkg::CMD_NEXT_DAY, cda_pkg::CMD_ADD_DAYS: begin
            if (!va_r) begin
              st_nxt = cda_pkg::ST_INVALID;
            end else if (step_sum > cda_pkg::serial_t'(cda_pkg::LAST_SERIAL)) begin
              st_nxt = cda_pkg::ST_OVERFLOW;
            end else begin
              // Decode the new serial back into a date.
              rem_nxt   = step_sum;
              acc_nxt   = '0;
              phase_nxt = cda_pkg::PH_400;
              cnt_nxt   = '0;
              pass_nxt  = cda_pkg::PASS_CONV;
              state_nxt = cda_pkg::S_YEAR;
            end
          end
          default: begin
            st_nxt = (va_r && vb_r) ? cda_pkg::ST_OK : cda_pkg::ST_INVALID;
          end
        endcase
      end

      cda_pkg::S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          o_day_nxt     = rday_r;
          o_mon_nxt     = rmon_r;
          o_year_nxt    = ryear_r;
          o_ord_nxt     = ord_r;
          o_diff_nxt    = diff_r;
          o_va_nxt      = va_r;
          o_vb_nxt      = vb_r;
          o_st_nxt      = st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = cda_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cda_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/cda_checker.sv]
// Port-level checker for the calendar date block, bound to its top level.
// Depends on cda_pkg and calendar_date_arithmetic_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "calendar_date_arithmetic_defines.svh"

module cda_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input cda_pkg::day_t    out_res_day,
  input cda_pkg::order_t  out_order,
  input cda_pkg::diff_t   out_day_difference,
  input logic             out_first_valid,
  input cda_pkg::status_t out_status
);

  // One item at a time: busy right after an accept.
  `CDA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A stalled result holds.
  `CDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_res_day))

  // Invalid input leaves every computed field at zero.
  `CDA_ASSERT_NOW(a_invalid_zero, out_valid && out_status == cda_pkg::ST_INVALID, out_res_day == '0 && out_order == '0 && out_day_difference == '0)

  // Every command uses the first date.
  `CDA_ASSERT_NOW(a_first_needed, out_valid && !out_first_valid, out_status == cda_pkg::ST_INVALID)

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_res_day        (out_ch.res_day),
  .out_order          (out_ch.order),
  .out_day_difference (out_ch.day_difference),
  .out_first_valid    (out_ch.first_valid),
  .out_status         (out_ch.status)
);

`default_nettype wire

[tb/calendar_date_arithmetic_tb.sv]
`timescale 1ns / 1ps
// Testbench for calendar_date_arithmetic: drives date command items over
// valid/ready, predicts every result with its own calendar arithmetic and
// checks it. Depends on cda_pkg, cda_if and the block itself.

module calendar_date_arithmetic_tb;
  import cda_pkg::*;

  // Spare command codes; the block treats them as validate.
  localparam cmd_t CMD_SPARE_FIRST = 3'd5;
  localparam cmd_t CMD_SPARE_LAST  = 3'd7;

  // These leave a wide margin over the longest item.
  localparam int LONG_STALL  = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 250;

  typedef struct {
    cmd_t   cmd;
    day_t   day_a;
    month_t month_a;
    year_t  year_a;
    day_t   day_b;
    month_t month_b;
    year_t  year_b;
    add_t   add_count;
  } date_cmd_t;

  typedef struct {
    day_t    day;
    month_t  month;
    year_t   year;
    order_t  order;
    diff_t   diff;
    logic    first_valid;
    logic    second_valid;
    status_t status;
  } date_result_t;

  logic clk;
  logic rst_n;

  cda_in_if  in_ch ();
  cda_out_if out_ch ();

  calendar_date_arithmetic dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Results predicted for accepted items, oldest first.
  date_result_t pending_results[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_asks     = 0;
  int stall_seen     = 0;
  int hold_left      = 0;
  int items_by_cmd[8];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the prediction. Dates map to a day number counted
  // from 1 Jan of year 1; the way back searches for the year, then walks the
  // months.
  // ---------------------------------------------------------------------------
  function automatic bit is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int m, int y);
    if (m < 1 || m > 12) begin
      return 0;
    end
    case (m)
      2:           return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_is_valid(int d, int m, int y);
    return (y >= 1) && (y <= MAX_YEAR) && (m >= 1) && (m <= 12) && (d >= 1)
           && (d <= month_length(m, y));
  endfunction

  function automatic int day_number(int d, int m, int y);
    int p;
    int n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int k = 1; k < m; k++) begin
      n += month_length(k, y);
    end
    return n + d - 1;
  endfunction

  function automatic void date_of_number(input int n, output int d, output int m,
                                         output int y);
    int rest;
    // No year is longer than 366 days, so this starts at or below the answer.
    y = n / 366 + 1;
    while (day_number(1, 1, y + 1) <= n) begin
      y++;
    end
    rest = n - day_number(1, 1, y);
    m = 1;
    while (rest >= month_length(m, y)) begin
      rest -= month_length(m, y);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic date_result_t predict_result(date_cmd_t c);
    date_result_t r;
    bit va;
    bit vb;
    int sa;
    int sb;
    int target;
    int d;
    int m;
    int y;
    int span;
    va = date_is_valid(c.day_a, c.month_a, c.year_a);
    vb = date_is_valid(c.day_b, c.month_b, c.year_b);
    r.day          = '0;
    r.month        = '0;
    r.year         = '0;
    r.order        = ORD_EQUAL;
    r.diff         = '0;
    r.first_valid  = va;
    r.second_valid = vb;
    r.status       = ST_OK;
    case (c.cmd)
      CMD_COMPARE, CMD_DAYS_BETWEEN: begin
        if (!va || !vb) begin
          r.status = ST_INVALID;
        end else begin
          sa = day_number(c.day_a, c.month_a, c.year_a);
          sb = day_number(c.day_b, c.month_b, c.year_b);
          if (c.cmd == CMD_COMPARE) begin
            r.order = (sa < sb) ? ORD_EARLIER : ((sa > sb) ? ORD_LATER : ORD_EQUAL);
          end else begin
            r.diff = diff_t'(sb - sa);
          end
        end
      end
      CMD_NEXT_DAY, CMD_ADD_DAYS: begin
        if (!va) begin
          r.status = ST_INVALID;
        end else begin
          // Only the low COUNT_WIDTH bits of the count take part.
          span = (c.cmd == CMD_NEXT_DAY) ? 1
                 : (int'(c.add_count) & ((1 << COUNT_WIDTH) - 1));
          target = day_number(c.day_a, c.month_a, c.year_a) + span;
          if (target > day_number(31, 12, MAX_YEAR)) begin
            r.status = ST_OVERFLOW;
          end else begin
            date_of_number(target, d, m, y);
            r.day   = day_t'(d);
            r.month = month_t'(m);
            r.year  = year_t'(y);
          end
        end
      end
      default: begin
        r.status = (va && vb) ? ST_OK : ST_INVALID;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready toggles at the falling edge, results are checked at the
  // rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    // A requested long hold-off starts here and is counted down locally.
    if (stall_seen != stall_asks) begin
      stall_seen = stall_asks;
      hold_left  = LONG_STALL;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic match_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item arrived with no accepted item waiting on it");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        match_field("res_day", want.day, out_ch.res_day);
        match_field("res_month", want.month, out_ch.res_month);
        match_field("res_year", want.year, out_ch.res_year);
        match_field("order", want.order, out_ch.order);
        match_field("day_difference", want.diff, out_ch.day_difference);
        match_field("first_valid", want.first_valid, out_ch.first_valid);
        match_field("second_valid", want.second_valid, out_ch.second_valid);
        match_field("status", want.status, out_ch.status);
      end
    end
    // Count cycles in which neither side moves an item.
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  // Watchdog: end the run if the block stops moving items.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("calendar_date_arithmetic_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input side. send_item is entered at a falling edge and returns at the
  // falling edge after acceptance, leaving valid high so back-to-back items
  // need no extra assignment.
  // ---------------------------------------------------------------------------
  task automatic send_item(cmd_t cmd, day_t da, month_t ma, year_t ya,
                           day_t db, month_t mb, year_t yb, add_t cnt);
    date_cmd_t c;
    int gap;
    c = '{cmd, da, ma, ya, db, mb, yb, cnt};
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c.cmd;
    in_ch.day_a     <= c.day_a;
    in_ch.month_a   <= c.month_a;
    in_ch.year_a    <= c.year_a;
    in_ch.day_b     <= c.day_b;
    in_ch.month_b   <= c.month_b;
    in_ch.year_b    <= c.year_b;
    in_ch.add_count <= c.add_count;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_results.push_back(predict_result(c));
    items_by_cmd[c.cmd]++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Mostly real dates, leaning on month ends, century years and both ends of
  // the year range; the rest is raw field noise.
  function automatic void pick_date(input bit well_formed, output day_t d,
                                    output month_t m, output year_t y);
    int sel;
    int yy;
    int mm;
    if (!well_formed) begin
      d = day_t'($urandom);
      m = month_t'($urandom);
      y = year_t'($urandom);
      return;
    end
    sel = $urandom_range(99);
    if (sel < 60) begin
      yy = $urandom_range(MAX_YEAR, 1);
    end else if (sel < 75) begin
      yy = $urandom_range(MAX_YEAR, MAX_YEAR - 9);
    end else if (sel < 85) begin
      yy = $urandom_range(12, 1);
    end else begin
      yy = 100 * $urandom_range(99, 1);
    end
    mm = $urandom_range(12, 1);
    d = ($urandom_range(3) == 0) ? day_t'(month_length(mm, yy))
        : day_t'($urandom_range(month_length(mm, yy), 1));
    m = month_t'(mm);
    y = year_t'(yy);
  endfunction

  task automatic send_random_item(cmd_t cmd);
    day_t   da;
    day_t   db;
    month_t ma;
    month_t mb;
    year_t  ya;
    year_t  yb;
    add_t   cnt;
    int     sel;
    pick_date($urandom_range(99) < 85, da, ma, ya);
    pick_date($urandom_range(99) < 85, db, mb, yb);
    // Now and then make both dates the same, so compare hits equality.
    if ($urandom_range(9) == 0) begin
      db = da;
      mb = ma;
      yb = ya;
    end
    sel = $urandom_range(99);
    if (sel < 40) begin
      cnt = add_t'($urandom);
    end else if (sel < 75) begin
      cnt = add_t'($urandom_range(400));
    end else begin
      cnt = add_t'($urandom_range(65535, 60000));
    end
    send_item(cmd, da, ma, ya, db, mb, yb, cnt);
  endtask

  function automatic cmd_t pick_cmd();
    if ($urandom_range(99) < 5) begin
      return cmd_t'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end
    return cmd_t'($urandom_range(CMD_DAYS_BETWEEN, CMD_VALIDATE));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_validate();
    // Range extremes, all-ones fields, leap day in leap, century and plain
    // years, 31st of a 30-day month, year past the top.
    send_item(CMD_VALIDATE, 5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, '0);
    send_item(CMD_VALIDATE, 5'd29, 4'd2, 14'd2000, 5'd29, 4'd2, 14'd1900, '0);
    send_item(CMD_VALIDATE, 5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383, '1);
    send_item(CMD_VALIDATE, 5'd31, 4'd4, 14'd2023, 5'd30, 4'd4, 14'd2023, '0);
    send_item(CMD_VALIDATE, 5'd29, 4'd2, 14'd2024, 5'd29, 4'd2, 14'd2023, '0);
    send_item(CMD_VALIDATE, 5'd1, 4'd13, 14'd10000, 5'd1, 4'd1, 14'd10000, '0);
  endtask

  task automatic test_compare();
    send_item(CMD_COMPARE, 5'd15, 4'd6, 14'd1987, 5'd15, 4'd6, 14'd1987, '0);
    send_item(CMD_COMPARE, 5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, '0);
    send_item(CMD_COMPARE, 5'd1, 4'd3, 14'd2000, 5'd29, 4'd2, 14'd2000, '0);
    send_item(CMD_COMPARE, 5'd30, 4'd2, 14'd2000, 5'd1, 4'd1, 14'd2000, '0);
  endtask

  task automatic test_next_day();
    send_item(CMD_NEXT_DAY, 5'd30, 4'd4, 14'd2021, '0, '0, '0, '0);
    send_item(CMD_NEXT_DAY, 5'd31, 4'd12, 14'd1999, '0, '0, '0, '0);
    send_item(CMD_NEXT_DAY, 5'd28, 4'd2, 14'd2024, '0, '0, '0, '0);
    send_item(CMD_NEXT_DAY, 5'd28, 4'd2, 14'd2023, '0, '0, '0, '0);
    send_item(CMD_NEXT_DAY, 5'd31, 4'd12, 14'd9999, '0, '0, '0, '0);
    send_item(CMD_NEXT_DAY, 5'd31, 4'd6, 14'd2020, '0, '0, '0, '0);
  endtask

  task automatic test_add_days();
    send_item(CMD_ADD_DAYS, 5'd31, 4'd12, 14'd9999, '0, '0, '0, 16'd0);
    send_item(CMD_ADD_DAYS, 5'd1, 4'd1, 14'd1, '0, '0, '0, 16'hffff);
    send_item(CMD_ADD_DAYS, 5'd1, 4'd1, 14'd9900, '0, '0, '0, 16'd40000);
    send_item(CMD_ADD_DAYS, 5'd28, 4'd2, 14'd1900, '0, '0, '0, 16'd1);
  endtask

  task automatic test_days_between();
    // Widest span both ways, then a leap day in a non-leap century year.
    send_item(CMD_DAYS_BETWEEN, 5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999, '0);
    send_item(CMD_DAYS_BETWEEN, 5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1, '0);
    send_item(CMD_DAYS_BETWEEN, 5'd29, 4'd2, 14'd2100, 5'd1, 4'd1, 14'd2000, '0);
  endtask

  task automatic test_spare_cmds();
    send_item(CMD_SPARE_FIRST, 5'd1, 4'd1, 14'd2000, 5'd2, 4'd2, 14'd2002, '0);
    send_item(CMD_SPARE_LAST, 5'd31, 4'd9, 14'd2000, 5'd2, 4'd2, 14'd2002, '0);
  endtask

  task automatic test_random_phase(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      send_random_item(pick_cmd());
    end
    wait_all_results();
  endtask

  // Hold the result side off while slow adds keep coming, so the output
  // register fills and the block stalls its input.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asks++;
    repeat (6) begin
      send_random_item(CMD_ADD_DAYS);
    end
    wait_all_results();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_VALIDATE;
    in_ch.day_a     = '0;
    in_ch.month_a   = '0;
    in_ch.year_a    = '0;
    in_ch.day_b     = '0;
    in_ch.month_b   = '0;
    in_ch.year_b    = '0;
    in_ch.add_count = '0;
    out_ch.ready    = 1'b0;
    foreach (items_by_cmd[i]) begin
      items_by_cmd[i] = 0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_validate();
    test_compare();
    test_next_day();
    test_add_days();
    test_days_between();
    test_spare_cmds();
    wait_all_results();

    test_random_phase(24, 9, 57);
    test_random_phase(24, 57, 9);
    test_back_pressure();
    test_random_phase(24, 0, 0);

    // Let any stray result show up before closing.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      mismatches++;
    end

    $display("covered validate %0d, compare %0d, next day %0d, add %0d, between %0d",
             items_by_cmd[CMD_VALIDATE], items_by_cmd[CMD_COMPARE],
             items_by_cmd[CMD_NEXT_DAY], items_by_cmd[CMD_ADD_DAYS],
             items_by_cmd[CMD_DAYS_BETWEEN]);
    $display("spare codes %0d; %0d results checked under idling and a long stall",
             items_by_cmd[5] + items_by_cmd[6] + items_by_cmd[7], results_seen);
    if (mismatches == 0) begin
      $display("calendar_date_arithmetic_tb: clean");
    end else begin
      $display("calendar_date_arithmetic_tb: errors");
    end
    $finish;
  end

endmodule
